// File: src/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, types and codes for the segment/plane intersection pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int COORD_W    = 32;   // Q16.16 coordinate
    localparam int DIFF_W     = 33;   // difference of two coordinates
    localparam int PROD_W     = 65;   // coordinate times difference
    localparam int DOT_W      = 67;   // sum of three products
    localparam int MAG_W      = 66;   // magnitude of a dot product
    localparam int HALF_W     = 33;   // split of a magnitude for the multiplier
    localparam int PART_W     = HALF_W + COORD_W;
    localparam int DIVIDEND_W = 100;
    localparam int DEN_W      = MAG_W + 1;
    localparam int Q_W        = 32;

    localparam int FRONT_STAGES = 3;
    localparam int CLASS_STAGES = 2;
    localparam int DIV_LATENCY  = Q_W + 2;
    localparam int TOTAL_STAGES = FRONT_STAGES + CLASS_STAGES + DIV_LATENCY + 1;

    typedef logic [2:0][COORD_W-1:0] vec_t;
    typedef logic [2:0][DIFF_W-1:0]  diff_vec_t;
    typedef logic [2:0][Q_W-1:0]     mag_vec_t;

    typedef enum logic [1:0] {
        CASE_DISJOINT = 2'd0,
        CASE_POINT    = 2'd1,
        CASE_IN_PLANE = 2'd2
    } hit_case_t;

    // travels alongside the dividers
    typedef struct packed {
        hit_case_t  hc;
        logic [2:0] u_neg;
        vec_t       p0;
    } meta_t;

endpackage

// File: src/segment_plane_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_plane_intersection_unit
// Segment against plane intersection in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction enters per clock and one result leaves per clock while
// out_ready holds; a waiting result stalls the pipe. The pipe holds the
// restoring dividers (one quotient bit per stage, 32 stages), three
// front stages (differences, products, dot products), two classify stages,
// two stages that build the dividend, and the output register. The whole
// pipe advances together: it moves whenever the output register is empty
// or its result is being taken, so in_ready only drops while a finished
// result waits at the output. The cfg_wr_data epsilon is compared against |n.u|
// in raw product units; write it only while the pipe is empty.
// ----------------------------------------------------------------------------
module segment_plane_intersection_unit
    import spi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] seg_start_x,
    input  logic [31:0] seg_start_y,
    input  logic [31:0] seg_start_z,
    input  logic [31:0] seg_end_x,
    input  logic [31:0] seg_end_y,
    input  logic [31:0] seg_end_z,
    input  logic [31:0] plane_point_x,
    input  logic [31:0] plane_point_y,
    input  logic [31:0] plane_point_z,
    input  logic [31:0] plane_normal_x,
    input  logic [31:0] plane_normal_y,
    input  logic [31:0] plane_normal_z,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  hit_case,
    output logic [31:0] hit_x,
    output logic [31:0] hit_y,
    output logic [31:0] hit_z
);

    logic en;                                   // global pipe advance
    logic [COORD_W-1:0] eps_reg;

    logic valid_reg [TOTAL_STAGES];

    // front
    vec_t                    p0_in, p1_in, v0_in, n_in;
    logic signed [DOT_W-1:0] d3, nn3;
    diff_vec_t               u3;
    vec_t                    p0_3;

    // classify, with the side data held alongside
    hit_case_t        hc5;
    logic [MAG_W-1:0] an5, ad5;
    mag_vec_t         umag4_reg, umag5_reg;
    logic [2:0]       uneg4_reg, uneg5_reg;
    vec_t             p04_reg, p05_reg;

    // dividers
    mag_vec_t q_div;
    meta_t    meta_reg [DIV_LATENCY];

    // output register
    hit_case_t          hc_out_reg;
    vec_t               hit_out_reg, hit_out_next;

    assign en       = !valid_reg[TOTAL_STAGES-1] || out_ready;
    assign in_ready = en;

    assign p0_in = {seg_start_z, seg_start_y, seg_start_x};
    assign p1_in = {seg_end_z, seg_end_y, seg_end_x};
    assign v0_in = {plane_point_z, plane_point_y, plane_point_x};
    assign n_in  = {plane_normal_z, plane_normal_y, plane_normal_x};

    // configuration register, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= COORD_W'(1);
        else if (cfg_wr_en)
            eps_reg <= cfg_wr_data;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL_STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < TOTAL_STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    spi_front u_front (
        .clk    (clk),
        .en     (en),
        .p0     (p0_in),
        .p1     (p1_in),
        .v0     (v0_in),
        .nrm    (n_in),
        .d      (d3),
        .nn     (nn3),
        .u      (u3),
        .p0_out (p0_3)
    );

    spi_classify u_classify (
        .clk (clk),
        .en  (en),
        .eps (eps_reg),
        .d   (d3),
        .nn  (nn3),
        .hc  (hc5),
        .an  (an5),
        .ad  (ad5)
    );

    // |u| never exceeds 2^32-1, so it fits the quotient width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                uneg4_reg[i] <= u3[i][DIFF_W-1];
                umag4_reg[i] <= u3[i][DIFF_W-1] ? Q_W'(-u3[i]) : Q_W'(u3[i]);
            end
            p04_reg   <= p0_3;
            umag5_reg <= umag4_reg;
            uneg5_reg <= uneg4_reg;
            p05_reg   <= p04_reg;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        spi_coord_div u_div (
            .clk  (clk),
            .en   (en),
            .an   (an5),
            .ad   (ad5),
            .umag (umag5_reg[g]),
            .q    (q_div[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= '{hc: hc5, u_neg: uneg5_reg, p0: p05_reg};
            for (int k = 1; k < DIV_LATENCY; k++)
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    // p0 +/- q, saturated; zero unless a single hit point
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [COORD_W+1:0] r;
            r = (COORD_W+2)'($signed(meta_reg[DIV_LATENCY-1].p0[i]));
            if (meta_reg[DIV_LATENCY-1].u_neg[i])
                r = r - $signed({2'b00, q_div[i]});
            else
                r = r + $signed({2'b00, q_div[i]});
            if (meta_reg[DIV_LATENCY-1].hc != CASE_POINT)
                hit_out_next[i] = '0;
            else if (r[COORD_W+1:COORD_W-1] == 3'b000 || r[COORD_W+1:COORD_W-1] == 3'b111)
                hit_out_next[i] = r[COORD_W-1:0];
            else if (r[COORD_W+1])
                hit_out_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                hit_out_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hc_out_reg  <= meta_reg[DIV_LATENCY-1].hc;
            hit_out_reg <= hit_out_next;
        end
    end

    assign out_valid = valid_reg[TOTAL_STAGES-1];
    assign hit_case  = hc_out_reg;
    assign hit_x     = hit_out_reg[0];
    assign hit_y     = hit_out_reg[1];
    assign hit_z     = hit_out_reg[2];

endmodule

// File: src/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// Differences, products and dot products D = n.u and N = -(n.w), three stages.
// ----------------------------------------------------------------------------
module spi_front
    import spi_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  vec_t                    p0,
    input  vec_t                    p1,
    input  vec_t                    v0,
    input  vec_t                    nrm,
    output logic signed [DOT_W-1:0] d,
    output logic signed [DOT_W-1:0] nn,
    output diff_vec_t               u,
    output vec_t                    p0_out
);

    diff_vec_t u1_reg, w1_reg, u1_next, w1_next;
    vec_t      n1_reg, p0_1_reg;

    logic [2:0][PROD_W-1:0] nu2_reg, nw2_reg, nu2_next, nw2_next;
    diff_vec_t u2_reg;
    vec_t      p0_2_reg;

    logic signed [DOT_W-1:0] d3_reg, nn3_reg, d3_next, nn3_next;
    diff_vec_t u3_reg;
    vec_t      p0_3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u1_next[i] = DIFF_W'($signed(p1[i])) - DIFF_W'($signed(p0[i]));
            w1_next[i] = DIFF_W'($signed(p0[i])) - DIFF_W'($signed(v0[i]));
            nu2_next[i] = PROD_W'($signed(n1_reg[i])) * PROD_W'($signed(u1_reg[i]));
            nw2_next[i] = PROD_W'($signed(n1_reg[i])) * PROD_W'($signed(w1_reg[i]));
        end
        d3_next  = DOT_W'($signed(nu2_reg[0])) + DOT_W'($signed(nu2_reg[1]))
                 + DOT_W'($signed(nu2_reg[2]));
        nn3_next = -(DOT_W'($signed(nw2_reg[0])) + DOT_W'($signed(nw2_reg[1]))
                 + DOT_W'($signed(nw2_reg[2])));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg   <= u1_next;
            w1_reg   <= w1_next;
            n1_reg   <= nrm;
            p0_1_reg <= p0;
            nu2_reg  <= nu2_next;
            nw2_reg  <= nw2_next;
            u2_reg   <= u1_reg;
            p0_2_reg <= p0_1_reg;
            d3_reg   <= d3_next;
            nn3_reg  <= nn3_next;
            u3_reg   <= u2_reg;
            p0_3_reg <= p0_2_reg;
        end
    end

    assign d      = d3_reg;
    assign nn     = nn3_reg;
    assign u      = u3_reg;
    assign p0_out = p0_3_reg;

endmodule

// File: src/spi_classify.sv
// ----------------------------------------------------------------------------
// spi_classify
// Magnitudes, parallel test and range test of s = N/D, two stages.
// ----------------------------------------------------------------------------
module spi_classify
    import spi_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [COORD_W-1:0]      eps,
    input  logic signed [DOT_W-1:0] d,
    input  logic signed [DOT_W-1:0] nn,
    output hit_case_t               hc,
    output logic [MAG_W-1:0]        an,
    output logic [MAG_W-1:0]        ad
);

    logic [MAG_W-1:0] ad4_reg, an4_reg, ad4_next, an4_next;
    logic             d_neg4_reg, n_neg4_reg, d_zero4_reg, n_zero4_reg;

    hit_case_t        hc5_reg, hc5_next;
    logic [MAG_W-1:0] ad5_reg, an5_reg;

    always_comb
    begin
        ad4_next = d[DOT_W-1]  ? MAG_W'(-d)  : MAG_W'(d);
        an4_next = nn[DOT_W-1] ? MAG_W'(-nn) : MAG_W'(nn);

        if (d_zero4_reg || (ad4_reg < MAG_W'(eps)))
            hc5_next = n_zero4_reg ? CASE_IN_PLANE : CASE_DISJOINT;
        else if (!n_zero4_reg && (n_neg4_reg != d_neg4_reg))
            hc5_next = CASE_DISJOINT;          // s below zero
        else if (an4_reg > ad4_reg)
            hc5_next = CASE_DISJOINT;          // s above one
        else
            hc5_next = CASE_POINT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad4_reg     <= ad4_next;
            an4_reg     <= an4_next;
            d_neg4_reg  <= d[DOT_W-1];
            n_neg4_reg  <= nn[DOT_W-1];
            d_zero4_reg <= (d == '0);
            n_zero4_reg <= (nn == '0);
            hc5_reg     <= hc5_next;
            ad5_reg     <= ad4_reg;
            an5_reg     <= an4_reg;
        end
    end

    assign hc = hc5_reg;
    assign an = an5_reg;
    assign ad = ad5_reg;

endmodule

// File: src/spi_coord_div.sv
// ----------------------------------------------------------------------------
// spi_coord_div
// Rounded quotient (2*an*umag + ad) / (2*ad): split multiply, then a
// restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module spi_coord_div
    import spi_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] an,
    input  logic [MAG_W-1:0] ad,
    input  logic [Q_W-1:0]   umag,
    output logic [Q_W-1:0]   q
);

    logic [PART_W-1:0] plo_reg, phi_reg;
    logic [MAG_W-1:0]  ada_reg;

    logic [DIVIDEND_W-1:0] dividend;

    // index 0 is the loaded dividend, index Q_W holds the finished quotient
    logic [DEN_W-1:0] rem_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   ql_reg  [Q_W+1];   // low dividend bits out, quotient bits in

    logic [DEN_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   ql_next  [Q_W];

    always_comb
    begin
        dividend = (DIVIDEND_W'(plo_reg) << 1)
                 + (DIVIDEND_W'(phi_reg) << (HALF_W + 1))
                 + DIVIDEND_W'(ada_reg);
        for (int k = 0; k < Q_W; k++)
        begin
            logic [DEN_W:0] trial;
            logic           ge;
            trial = {rem_reg[k], ql_reg[k][Q_W-1]};
            ge    = (trial >= {1'b0, den_reg[k]});
            rem_next[k] = ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : DEN_W'(trial);
            ql_next[k]  = {ql_reg[k][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg    <= PART_W'(an[HALF_W-1:0]) * PART_W'(umag);
            phi_reg    <= PART_W'(an[MAG_W-1:HALF_W]) * PART_W'(umag);
            ada_reg    <= ad;
            rem_reg[0] <= dividend[Q_W +: DEN_W];
            ql_reg[0]  <= dividend[Q_W-1:0];
            den_reg[0] <= {ada_reg, 1'b0};
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                ql_reg[k+1]  <= ql_next[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign q = ql_reg[Q_W];

endmodule

// File: src/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker
// Port-level checks on the intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module spi_checker
    import spi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  hit_case,
    input logic [31:0] hit_x,
    input logic [31:0] hit_y,
    input logic [31:0] hit_z
);

    // a stalled result holds its case and x coordinate
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_case) && $stable(hit_x))
        else $error("result changed while stalled");

    // hit point is zero unless a single point
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_case != CASE_POINT |-> hit_x == 0 && hit_y == 0 && hit_z == 0)
        else $error("nonzero point without a hit");

    a_case_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit_case != 2'd3)
        else $error("bad case code");

    // input only stalls behind a waiting result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with output free");

endmodule

bind segment_plane_intersection_unit spi_checker u_spi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit_case  (hit_case),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z)
);

// File: sim/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_scoreboard
// Watches the input, output and epsilon ports of the intersection unit,
// predicts each hit result and compares it with what the unit returns.
// ----------------------------------------------------------------------------
module spi_scoreboard
    import spi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] seg_start_x,
    input  logic [31:0] seg_start_y,
    input  logic [31:0] seg_start_z,
    input  logic [31:0] seg_end_x,
    input  logic [31:0] seg_end_y,
    input  logic [31:0] seg_end_z,
    input  logic [31:0] plane_point_x,
    input  logic [31:0] plane_point_y,
    input  logic [31:0] plane_point_z,
    input  logic [31:0] plane_normal_x,
    input  logic [31:0] plane_normal_y,
    input  logic [31:0] plane_normal_z,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  hit_case,
    input  logic [31:0] hit_x,
    input  logic [31:0] hit_y,
    input  logic [31:0] hit_z,
    output int          errors,
    output int          pending,
    output int          point_hits,
    output int          in_plane_hits,
    output int          misses
);

    typedef struct packed {
        hit_case_t   hc;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } hit_t;

    hit_t        hit_queue[$];
    logic [31:0] eps_shadow;

    // Exact wide-integer intersection with round-half-away division.
    function automatic hit_t predict_hit(input logic [2:0][31:0] p0,
                                         input logic [2:0][31:0] p1,
                                         input logic [2:0][31:0] v0,
                                         input logic [2:0][31:0] nv,
                                         input logic [31:0] eps);
        logic signed [127:0] d, nn, a, b, r;
        logic signed [127:0] u[3];
        logic [127:0]        ad, an, mu, q;
        hit_t                h;
        d = 0;
        nn = 0;
        h = '0;
        h.hc = CASE_DISJOINT;
        for (int i = 0; i < 3; i++)
        begin
            a = $signed(nv[i]);
            u[i] = $signed(p1[i]) - $signed(p0[i]);
            b = $signed(p0[i]) - $signed(v0[i]);
            d = d + a * u[i];
            nn = nn + a * b;
        end
        nn = -nn;
        ad = (d < 0) ? -d : d;
        an = (nn < 0) ? -nn : nn;
        if (d == 0 || ad < {96'd0, eps})
        begin
            h.hc = (nn == 0) ? CASE_IN_PLANE : CASE_DISJOINT;
            return h;
        end
        if (nn != 0 && ((nn < 0) != (d < 0)))
            return h;
        if (an > ad)
            return h;
        for (int i = 0; i < 3; i++)
        begin
            mu = (u[i] < 0) ? -u[i] : u[i];
            q = (2 * an * mu + ad) / (2 * ad);
            r = (u[i] < 0) ? $signed(p0[i]) - $signed(q) : $signed(p0[i]) + $signed(q);
            if (r > 128'sd2147483647)
                r = 128'sd2147483647;
            if (r < -128'sd2147483648)
                r = -128'sd2147483648;
            case (i)
                0: h.x = r[31:0];
                1: h.y = r[31:0];
                default: h.z = r[31:0];
            endcase
        end
        h.hc = CASE_POINT;
        return h;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    assign pending = hit_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        hit_t exp_hit;
        if (!rst_n)
        begin
            eps_shadow    <= 32'd1;
            errors        = 0;
            point_hits    = 0;
            in_plane_hits = 0;
            misses        = 0;
            hit_queue.delete();
        end
        else
        begin
            if (cfg_wr_en)
                eps_shadow <= cfg_wr_data;
            if (in_valid && in_ready)
                hit_queue = {hit_queue, predict_hit(
                    {seg_start_z, seg_start_y, seg_start_x},
                    {seg_end_z, seg_end_y, seg_end_x},
                    {plane_point_z, plane_point_y, plane_point_x},
                    {plane_normal_z, plane_normal_y, plane_normal_x},
                    eps_shadow)};
            if (out_valid && out_ready)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("unexpected transaction", {30'd0, hit_case}, 32'd0);
                else
                begin
                    exp_hit = hit_queue.pop_front();
                    case (exp_hit.hc)
                        CASE_POINT:    point_hits++;
                        CASE_IN_PLANE: in_plane_hits++;
                        default:       misses++;
                    endcase
                    if (hit_case != exp_hit.hc)
                        report_mismatch("hit_case", {30'd0, hit_case}, {30'd0, exp_hit.hc});
                    if (hit_x != exp_hit.x)
                        report_mismatch("hit_x", hit_x, exp_hit.x);
                    if (hit_y != exp_hit.y)
                        report_mismatch("hit_y", hit_y, exp_hit.y);
                    if (hit_z != exp_hit.z)
                        report_mismatch("hit_z", hit_z, exp_hit.z);
                end
            end
        end
    end

endmodule

// File: sim/tb_segment_plane_intersection_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_plane_intersection_unit
// Drives segment/plane queries through the unit under random flow control
// and epsilon settings; spi_scoreboard predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_segment_plane_intersection_unit
    import spi_pkg::*;
();

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = TOTAL_STAGES + 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] fld[12];   // start xyz, end xyz, plane point xyz, normal xyz
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  hit_case;
    logic [31:0] hit_x, hit_y, hit_z;

    int errors, pending, point_hits, in_plane_hits, misses;
    int cycles;
    int sent;
    bit calm;   // no idling on either side while set

    segment_plane_intersection_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .seg_start_x(fld[0]), .seg_start_y(fld[1]), .seg_start_z(fld[2]),
        .seg_end_x(fld[3]), .seg_end_y(fld[4]), .seg_end_z(fld[5]),
        .plane_point_x(fld[6]), .plane_point_y(fld[7]), .plane_point_z(fld[8]),
        .plane_normal_x(fld[9]), .plane_normal_y(fld[10]), .plane_normal_z(fld[11]),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit_case(hit_case), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
    );

    spi_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .seg_start_x(fld[0]), .seg_start_y(fld[1]), .seg_start_z(fld[2]),
        .seg_end_x(fld[3]), .seg_end_y(fld[4]), .seg_end_z(fld[5]),
        .plane_point_x(fld[6]), .plane_point_y(fld[7]), .plane_point_z(fld[8]),
        .plane_normal_x(fld[9]), .plane_normal_y(fld[10]), .plane_normal_z(fld[11]),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit_case(hit_case), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
        .errors(errors), .pending(pending), .point_hits(point_hits),
        .in_plane_hits(in_plane_hits), .misses(misses)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure: ~18% stall, none while calm.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 18);

    // One query transaction. Valid stays up across back-to-back items; each
    // cycle before an item idles with ~18% odds. in_ready only changes at
    // the rising edge, so reading it at the falling edge is race free.
    task automatic send_query(input logic [31:0] q[12]);
        bit took;
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 12; i++)
            fld[i] <= q[i];
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        sent++;
    endtask

    // Epsilon only changes with the pipe empty.
    task automatic write_epsilon(input logic [31:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Plane crossing the segment at fraction k/256; small coordinates keep
    // the construction in range. Endpoint hits at k = 0 and k = 256.
    function automatic void make_crossing(output logic [31:0] q[12], input int k);
        longint a, b;
        for (int i = 0; i < 3; i++)
        begin
            a = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
            b = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
            q[i]     = a[31:0];
            q[3 + i] = b[31:0];
            q[6 + i] = 32'(a + (((b - a) * k) >>> 8));
            q[9 + i] = $urandom();
        end
    endfunction

    // Direction perpendicular to the normal, so n.u is exactly zero.
    function automatic void make_parallel(output logic [31:0] q[12], input bit on_plane);
        longint ua, ub, m;
        for (int i = 0; i < 12; i++)
            q[i] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        ua = $signed(q[9][23:0]);
        ub = $signed(q[10][23:0]);
        m  = $urandom_range(1, 255);
        q[11] = $urandom();
        q[3] = 32'(longint'($signed(q[0])) - ub * m / 1024);
        q[4] = 32'(longint'($signed(q[1])) + ua * m / 1024);
        q[9]  = 32'(ua * 4);
        q[10] = 32'(ub * 4);
        q[3] = 32'(longint'($signed(q[0])) - ub * m);
        q[4] = 32'(longint'($signed(q[1])) + ua * m);
        q[5] = q[2];
        if (on_plane)
        begin
            q[6] = q[0];
            q[7] = q[1];
            q[8] = q[2];
        end
    endfunction

    task automatic random_item();
        logic [31:0] q[12];
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            make_crossing(q, $urandom_range(0, 256));
        else if (pick < 75)
            make_parallel(q, 1'($urandom_range(1)));
        else
            for (int i = 0; i < 12; i++)
                q[i] = $urandom();
        send_query(q);
    endtask

    initial
    begin
        logic [31:0] q[12];
        cycles      = 0;
        sent        = 0;
        calm        = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 32'd0;
        out_ready   = 1'b0;
        for (int i = 0; i < 12; i++)
            fld[i] = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes at reset epsilon.
        for (int i = 0; i < 12; i++) q[i] = 32'h7FFF_FFFF;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = 32'h8000_0000;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = 32'd0;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = (i < 3 || i >= 9) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = (i < 3 || i >= 9) ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_query(q);
        make_crossing(q, 0);   send_query(q);   // hit exactly at start
        make_crossing(q, 256); send_query(q);   // hit exactly at end
        make_crossing(q, 128); send_query(q);
        make_parallel(q, 1);   send_query(q);   // segment lies in plane
        make_parallel(q, 0);   send_query(q);   // parallel, off plane

        // Zero epsilon: only an exact zero n.u is parallel.
        write_epsilon(32'd0);
        make_parallel(q, 1);   send_query(q);
        make_parallel(q, 0);   send_query(q);
        make_crossing(q, 64);  send_query(q);
        // Largest epsilon: every |n.u| below 32'hFFFF_FFFF counts as parallel.
        write_epsilon(32'hFFFF_FFFF);
        make_crossing(q, 64);  send_query(q);
        make_parallel(q, 1);   send_query(q);
        for (int i = 0; i < 12; i++) q[i] = $urandom();
        send_query(q);

        // Random phases, each under its own epsilon.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_epsilon(32'd1);
                1: write_epsilon(32'd0);
                2: write_epsilon($urandom());
                3: write_epsilon(32'hFFFF_FFFF);
                default: write_epsilon(32'h0001_0000);
            endcase
            calm = (phase == 2);   // one long stretch with no stalls
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
                random_item();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d queries over several epsilon settings and random flow control",
                 sent);
        $display("Results: %0d point hits, %0d in-plane, %0d disjoint",
                 point_hits, in_plane_hits, misses);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
